>>> rtl/aes128_cbc_block_cipher_assert.svh
// Assertion macros for the RTL of the CBC block cipher.
`ifndef AES128_CBC_BLOCK_CIPHER_ASSERT_SVH
`define AES128_CBC_BLOCK_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
`define AES_CBC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("aes_cbc assertion failed");
`define AES_CBC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("aes_cbc assertion failed");
`else
`define AES_CBC_ASSERT(lbl, clk, rst_n, prop)
`define AES_CBC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/aes_cbc_pkg.sv
package aes_cbc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KEY_HIGH     = 3'd0;
  localparam logic [2:0] CFG_KEY_LOW      = 3'd1;
  localparam logic [2:0] CFG_IV_HIGH      = 3'd2;
  localparam logic [2:0] CFG_IV_LOW       = 3'd3;
  localparam logic [2:0] CFG_DECRYPT_MODE = 3'd4;

  localparam int unsigned NUM_ROUNDS = 10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Round constant for the key word that opens round key number idx + 1.
  function automatic logic [7:0] rcon(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0: r = 8'h01;
      4'd1: r = 8'h02;
      4'd2: r = 8'h04;
      4'd3: r = 8'h08;
      4'd4: r = 8'h10;
      4'd5: r = 8'h20;
      4'd6: r = 8'h40;
      4'd7: r = 8'h80;
      4'd8: r = 8'h1b;
      4'd9: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Next 128-bit round key from the current one.
  function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                  input logic [3:0] idx);
    logic [31:0] w3;
    logic [31:0] t;
    logic [31:0] n0;
    logic [31:0] n1;
    logic [31:0] n2;
    logic [31:0] n3;
    w3 = rk[31:0];
    t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    t  = t ^ {rcon(idx), 24'h0};
    n0 = rk[127:96] ^ t;
    n1 = rk[95:64] ^ n0;
    n2 = rk[63:32] ^ n1;
    n3 = rk[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [7:0] gm2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the state sits at bits 127-8i down to 120-8i.
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
    end
    return t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+4-r)%4)) -: 8];
        end else begin
          t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m0 [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = s[127-8*(r+4*c) -: 8];
        x2[r] = gm2(a[r]);
        x4[r] = gm2(x2[r]);
        x8[r] = gm2(x4[r]);
        // Coefficients 2,3,1,1 forward and 14,11,13,9 inverse.
        m0[r] = inv ? (x8[r] ^ x4[r] ^ x2[r]) : x2[r];
        m1[r] = inv ? (x8[r] ^ x2[r] ^ a[r]) : (x2[r] ^ a[r]);
        m2[r] = inv ? (x8[r] ^ x4[r] ^ a[r]) : a[r];
        m3[r] = inv ? (x8[r] ^ a[r]) : a[r];
      end
      t[127-8*(4*c)   -: 8] = m0[0] ^ m1[1] ^ m2[2] ^ m3[3];
      t[127-8*(4*c+1) -: 8] = m3[0] ^ m0[1] ^ m1[2] ^ m2[3];
      t[127-8*(4*c+2) -: 8] = m2[0] ^ m3[1] ^ m0[2] ^ m1[3];
      t[127-8*(4*c+3) -: 8] = m1[0] ^ m2[1] ^ m3[2] ^ m0[3];
    end
    return t;
  endfunction

endpackage

>>> rtl/aes_cbc_ram.sv
module aes_cbc_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/aes128_cbc_block_cipher.sv
// AES-128 in CBC mode, one 128-bit block per word on the input channel, one result
// word per input word. From acceptance an item goes through ST_LOAD, which fetches
// the first round key, ST_ROUND, which makes the initial key addition and then the
// AES rounds against the round-key memory, and ST_DONE, which chains and delivers
// to the output register once it is free. The round keys live in an 11-entry by
// 128-bit memory; after a write to either key register the next item first expands
// the key into it, one round key a cycle, which delays that item only. Input is
// taken only while no item is in flight; a result waiting in the output register
// does not hold off the next item. Configuration writes are always ready and are
// meant to be made while the block is idle; decrypt_mode uses bit 0 of the data.
module aes128_cbc_block_cipher
  import aes_cbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_first_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

`include "aes128_cbc_block_cipher_assert.svh"

  localparam int unsigned RK_DEPTH = NUM_ROUNDS + 1;
  localparam int unsigned AW       = $clog2(RK_DEPTH);
  localparam logic [3:0]  LAST     = 4'(NUM_ROUNDS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } state_t;

  state_t        state_r;
  logic [3:0]    cnt_r;
  logic          keys_ok_r;
  logic [63:0]   key_high_r;
  logic [63:0]   key_low_r;
  logic [63:0]   iv_high_r;
  logic [63:0]   iv_low_r;
  logic          decrypt_r;
  logic [127:0]  chain_r;
  logic [127:0]  block_r;
  logic [127:0]  s_r;
  logic [127:0]  rk_r;
  logic          out_valid_r;
  logic [127:0]  out_r;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [127:0]  ram_rdata;
  logic [127:0]  s_nxt;
  logic [127:0]  enc_t;
  logic [127:0]  dec_t;
  logic [127:0]  cv;
  logic          in_acc;
  logic          out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_high  = out_r[127:64];
  assign out_low   = out_r[63:0];
  assign cv        = in_first_block ? {iv_high_r, iv_low_r} : chain_r;

  aes_cbc_ram #(
    .WIDTH(128),
    .DEPTH(RK_DEPTH)
  ) u_rk_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(rk_r),
    .rdata(ram_rdata)
  );

  // Memory address: key writes during expansion, round-key reads one step ahead.
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = '0;
    case (state_r)
      ST_EXPAND: begin
        ram_we   = 1'b1;
        ram_addr = AW'(cnt_r);
      end
      ST_LOAD: begin
        ram_addr = decrypt_r ? AW'(LAST) : '0;
      end
      ST_ROUND: begin
        if (cnt_r < LAST) begin
          ram_addr = decrypt_r ? AW'(LAST - 4'd1 - cnt_r) : AW'(cnt_r + 4'd1);
        end
      end
      default: begin
        ram_addr = '0;
      end
    endcase
  end

  // One AES round per cycle, step zero being the initial key addition.
  always_comb begin
    enc_t = shift_rows(sub_bytes(s_r, 1'b0), 1'b0);
    if (cnt_r != LAST) begin
      enc_t = mix_columns(enc_t, 1'b0);
    end
    dec_t = sub_bytes(shift_rows(s_r, 1'b1), 1'b1) ^ ram_rdata;
    if (cnt_r != LAST) begin
      dec_t = mix_columns(dec_t, 1'b1);
    end
    if (cnt_r == 4'd0) begin
      s_nxt = s_r ^ ram_rdata;
    end else if (decrypt_r) begin
      s_nxt = dec_t;
    end else begin
      s_nxt = enc_t ^ ram_rdata;
    end
  end

  // Control sequencer, configuration registers and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      keys_ok_r   <= 1'b0;
      key_high_r  <= '0;
      key_low_r   <= '0;
      iv_high_r   <= '0;
      iv_low_r    <= '0;
      decrypt_r   <= 1'b0;
      chain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The delivery state refills the output register itself.
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY_HIGH: begin
            key_high_r <= cfg_data;
            keys_ok_r  <= 1'b0;
          end
          CFG_KEY_LOW: begin
            key_low_r <= cfg_data;
            keys_ok_r <= 1'b0;
          end
          CFG_IV_HIGH:      iv_high_r <= cfg_data;
          CFG_IV_LOW:       iv_low_r  <= cfg_data;
          CFG_DECRYPT_MODE: decrypt_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            block_r <= {in_block_high, in_block_low};
            chain_r <= cv;
            s_r     <= decrypt_r ? {in_block_high, in_block_low}
                                 : ({in_block_high, in_block_low} ^ cv);
            rk_r    <= {key_high_r, key_low_r};
            cnt_r   <= '0;
            state_r <= keys_ok_r ? ST_LOAD : ST_EXPAND;
          end
        end
        ST_EXPAND: begin
          rk_r <= next_round_key(rk_r, cnt_r);
          if (cnt_r == LAST) begin
            cnt_r     <= '0;
            keys_ok_r <= 1'b1;
            state_r   <= ST_LOAD;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_LOAD: begin
          cnt_r   <= '0;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          s_r <= s_nxt;
          if (cnt_r == LAST) begin
            state_r <= ST_DONE;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (decrypt_r) begin
              out_r   <= s_r ^ chain_r;
              chain_r <= block_r;
            end else begin
              out_r   <= s_r;
              chain_r <= s_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The key memory is never written while rounds read from it.
  `AES_CBC_ASSERT(a_no_write_in_rounds, clk, rst_n, (state_r == ST_ROUND) |-> !ram_we)
  // An item arriving with a stale schedule expands the key first.
  `AES_CBC_ASSERT(a_stale_expands, clk, rst_n,
    (in_acc && !keys_ok_r && !(cfg_valid && cfg_index == CFG_DECRYPT_MODE)) |=>
      (state_r == ST_EXPAND))
  // The schedule becomes valid only at the end of an expansion.
  `AES_CBC_ASSERT(a_keys_from_expand, clk, rst_n,
    $rose(keys_ok_r) |-> ($past(state_r) == ST_EXPAND))

endmodule

>>> dv/aes128_cbc_block_cipher_test.sv
module aes128_cbc_block_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_cbc_pkg::*;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
  } block_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_block_high = '0;
  logic [63:0] in_block_low = '0;
  logic        in_first_block = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes128_cbc_block_cipher i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_block_high(in_block_high), .in_block_low(in_block_low),
    .in_first_block(in_first_block),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_high(out_high), .out_low(out_low),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Blocks waiting to be offered and cipher results still owed by the block.
  block_word_t  blocks_to_send[$];
  logic [127:0] expected_blocks[$];
  int unsigned  error_count = 0;
  int unsigned  send_gap_pct = 0;
  int unsigned  out_stall_pct = 0;
  logic         hold_go = 1'b0;
  logic         hold_started = 1'b0;
  int unsigned  hold_cycles = 0;

  // Shadow of the configuration and the chaining value.
  logic [63:0] key_hi = '0, key_lo = '0, iv_hi = '0, iv_lo = '0;
  logic        decrypt_on = 1'b0;
  logic [63:0] chain_hi = '0, chain_lo = '0;

  logic [7:0]  fwd_sub[256];
  logic [7:0]  inv_sub[256];
  logic [31:0] key_words[44];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // Substitution boxes from the field inverse and the affine map.
  task automatic build_sub_boxes();
    logic [7:0] v;
    logic [7:0] s;
    for (int a = 0; a < 256; a++) begin
      v = '0;
      for (int b = 1; b < 256; b++) begin
        if (gf_mul(a[7:0], b[7:0]) == 8'h01) v = b[7:0];
      end
      s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]}
          ^ 8'h63;
      fwd_sub[a] = s;
      inv_sub[s] = a[7:0];
    end
  endtask

  task automatic expand_cipher_key();
    logic [31:0] t;
    logic [7:0]  rc;
    key_words[0] = key_hi[63:32];
    key_words[1] = key_hi[31:0];
    key_words[2] = key_lo[63:32];
    key_words[3] = key_lo[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = key_words[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_sub[t[31:24]] ^ rc, fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
        rc = gf_mul(rc, 8'h02);
      end
      key_words[i] = key_words[i-4] ^ t;
    end
  endtask

  // One AES-128 block; byte i of the block sits at bits 127-8i.
  function automatic logic [127:0] aes_block(input logic [127:0] blk, input logic dec);
    logic [7:0] st[16];
    logic [7:0] tmp[16];
    logic [7:0] k0, k1, k2, k3;
    logic [127:0] res;
    int rnd;
    k0 = dec ? 8'h0e : 8'h02;
    k1 = dec ? 8'h0b : 8'h03;
    k2 = dec ? 8'h0d : 8'h01;
    k3 = dec ? 8'h09 : 8'h01;
    for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
    for (int step = 0; step <= 10; step++) begin
      rnd = dec ? 10 - step : step;
      if (step != 0) begin
        // Substitution and row shift, in either order since they commute.
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            if (dec) tmp[r+4*c] = inv_sub[st[r+4*((c+4-r)%4)]];
            else tmp[r+4*c] = fwd_sub[st[r+4*((c+r)%4)]];
          end
        end
        st = tmp;
      end
      // Forward mixing happens before the round key, inverse after it.
      if (!dec && step != 0 && step != 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            tmp[r+4*c] = gf_mul(st[4*c+r], k0) ^ gf_mul(st[4*c+(r+1)%4], k1)
                         ^ gf_mul(st[4*c+(r+2)%4], k2) ^ gf_mul(st[4*c+(r+3)%4], k3);
          end
        end
        st = tmp;
      end
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          st[r+4*c] = st[r+4*c] ^ key_words[4*rnd+c][31-8*r -: 8];
        end
      end
      if (dec && step != 0 && step != 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            tmp[r+4*c] = gf_mul(st[4*c+r], k0) ^ gf_mul(st[4*c+(r+1)%4], k1)
                         ^ gf_mul(st[4*c+(r+2)%4], k2) ^ gf_mul(st[4*c+(r+3)%4], k3);
          end
        end
        st = tmp;
      end
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  // CBC step for one accepted word; queues the expected result.
  task automatic predict_cbc(input block_word_t w);
    logic [127:0] res;
    expand_cipher_key();
    if (w.first_block) begin
      chain_hi = iv_hi;
      chain_lo = iv_lo;
    end
    if (!decrypt_on) begin
      res = aes_block({w.block_high ^ chain_hi, w.block_low ^ chain_lo}, 1'b0);
      {chain_hi, chain_lo} = res;
    end else begin
      res = aes_block({w.block_high, w.block_low}, 1'b1) ^ {chain_hi, chain_lo};
      chain_hi = w.block_high;
      chain_lo = w.block_low;
    end
    expected_blocks.push_back(res);
  endtask

  // Driver: offers queued words, with random gaps.
  always @(posedge clk) begin
    block_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_cbc({in_block_high, in_block_low, in_first_block});
      if (blocks_to_send.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        w = blocks_to_send.pop_front();
        in_block_high <= w.block_high;
        in_block_low <= w.block_low;
        in_first_block <= w.first_block;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_go && !hold_started) begin
      hold_started <= 1'b1;
      hold_cycles <= 400;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Monitor: checks each result word against the oldest expectation.
  always @(posedge clk) begin
    logic [127:0] exp_blk;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $error("result word with no expectation: %h %h", out_high, out_low);
          error_count++;
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (out_high !== exp_blk[127:64]) begin
            $error("out_high expected %h actual %h", exp_blk[127:64], out_high);
            error_count++;
          end
          if (out_low !== exp_blk[63:0]) begin
            $error("out_low expected %h actual %h", exp_blk[63:0], out_low);
            error_count++;
          end
        end
      end
      out_stall <= (hold_go && (!hold_started || hold_cycles > 1)) ||
                   ($urandom_range(99) < out_stall_pct);
    end
  end

  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_KEY_HIGH: key_hi = value;
      CFG_KEY_LOW: key_lo = value;
      CFG_IV_HIGH: iv_hi = value;
      CFG_IV_LOW: iv_lo = value;
      CFG_DECRYPT_MODE: decrypt_on = value[0];
      default: ;
    endcase
  endtask

  // Waits until every word was sent and every result came, plus key expansion slack.
  // The queues are looked at mid-cycle, once the driver's updates have settled.
  task automatic drain();
    while (blocks_to_send.size() > 0 || in_valid || expected_blocks.size() > 0) begin
      @(negedge clk);
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo, input logic fb);
    block_word_t w;
    w.block_high = hi;
    w.block_low = lo;
    w.first_block = fb;
    blocks_to_send.push_back(w);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random messages, mostly restarting at the IV, some chained on.
  task automatic queue_messages(input int unsigned count);
    int unsigned len;
    int unsigned n;
    n = 0;
    while (n < count) begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        queue_block(rand64(), rand64(), (i == 0) && ($urandom_range(9) != 0));
      end
      if ($urandom_range(19) == 0) queue_block(rand64(), rand64(), 1'($urandom_range(1)));
      n += len;
    end
  endtask

  initial begin
    build_sub_boxes();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: chaining from the reset value, extremes, the standard vector.
    queue_block(64'h0, 64'h0, 1'b0);
    queue_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0);
    queue_block(64'h0, 64'h0, 1'b1);
    drain();
    write_register(CFG_KEY_HIGH, 64'h0001_0203_0405_0607);
    write_register(CFG_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
    queue_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 1'b1);
    queue_block(64'hffff_ffff_ffff_ffff, 64'h0, 1'b0);
    drain();
    write_register(CFG_IV_HIGH, 64'hffff_ffff_ffff_ffff);
    write_register(CFG_IV_LOW, 64'hffff_ffff_ffff_ffff);
    write_register(3'd5, rand64());
    write_register(3'd7, rand64());
    queue_block(64'h0, 64'hffff_ffff_ffff_ffff, 1'b1);
    queue_block(rand64(), rand64(), 1'b0);
    drain();
    // Decrypt continues the chain as it stands; only bit zero of the data counts.
    write_register(CFG_DECRYPT_MODE, 64'hffff_ffff_ffff_fffe);
    queue_block(rand64(), rand64(), 1'b0);
    drain();
    write_register(CFG_DECRYPT_MODE, 64'h3);
    queue_block(rand64(), rand64(), 1'b0);
    queue_block(64'h0, 64'h0, 1'b1);
    queue_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0);
    drain();
    // A key change mid-message keeps the chain.
    write_register(CFG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
    write_register(CFG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
    queue_block(rand64(), rand64(), 1'b0);
    queue_block(rand64(), rand64(), 1'b1);
    drain();

    // Random phases with new settings and idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_register(CFG_KEY_HIGH, 64'h0);
          write_register(CFG_KEY_LOW, 64'h0);
          write_register(CFG_IV_HIGH, 64'h0);
          write_register(CFG_IV_LOW, 64'h0);
        end
        default: begin
          write_register(CFG_KEY_HIGH, rand64());
          write_register(CFG_KEY_LOW, rand64());
          write_register(CFG_IV_HIGH, rand64());
          write_register(CFG_IV_LOW, rand64());
        end
      endcase
      write_register(CFG_DECRYPT_MODE, {$urandom, $urandom_range(1) == 1 ? 32'h1 : 32'h0});
      case (ph % 4)
        0: begin send_gap_pct = 0; out_stall_pct = 0; end
        1: begin send_gap_pct = 78; out_stall_pct = 0; end
        2: begin send_gap_pct = 0; out_stall_pct = 78; end
        default: begin send_gap_pct = 16; out_stall_pct = 16; end
      endcase
      if (ph == 4) hold_go = 1'b1;
      queue_messages(270);
      drain();
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/aes_cbc_pkg.sv
rtl/aes_cbc_ram.sv
rtl/aes128_cbc_block_cipher.sv
dv/aes128_cbc_block_cipher_test.sv
